// ----- rtl/dsc_pkg.sv -----
// shared types and constants of the deadlock safety check block
package dsc_pkg;

    // item codes carried on the mode port
    typedef enum logic [1:0] {
        OP_AVAIL   = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_REQUEST = 2'd2,
        OP_CHECK   = 2'd3
    } op_t;

    localparam int THREAD_IDX_W = 4;
    localparam int RES_IDX_W    = 3;
    localparam int COUNT_W      = 8;
    localparam int WORK_W       = 13;
    localparam logic [WORK_W-1:0] WORK_MAX = '1;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef struct packed {
        op_t                     op;
        logic [THREAD_IDX_W-1:0] thread;
        logic [RES_IDX_W-1:0]    res;
        logic [COUNT_W-1:0]      value;
    } cmd_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SCAN
    } back_state_t;

endpackage

// ----- rtl/deadlock_safety_check_core.sv -----
// top level of the deadlock safety check block
//
//  channel   direction  handshake            payload
//  command   in         start high, busy low mode, thread_index, resource_index, count_value
//  result    out        done strobe          deadlocked
//
// unless busy, loads are taken one per cycle and reach the stores at the edge they leave the queue
// a check scans the thread rows in passes in the back end, one thread row per cycle
// from the count memories; passes is at most THREADS + 1, result strobes the cycle after the last pass
// after reset the back end clears both count memories, one row per cycle, and busy stays
// high during that time
// busy also rises while the two-entry command queue is full; results cannot be stalled
module deadlock_safety_check_core
    import dsc_pkg::*;
#(
    parameter int THREADS   = 16,
    parameter int RESOURCES = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              mode,
    input  logic [THREAD_IDX_W-1:0] thread_index,
    input  logic [RES_IDX_W-1:0]    resource_index,
    input  logic [COUNT_W-1:0]      count_value,
    output logic                    done,
    output logic                    deadlocked
);

    logic q_full;
    logic q_valid;
    logic q_pop;
    logic push;
    logic clearing;
    cmd_t push_cmd;
    cmd_t q_head;

    // decode and range check
    dsc_front #(
        .THREADS   (THREADS),
        .RESOURCES (RESOURCES)
    ) u_front (
        .start          (start),
        .mode           (mode),
        .thread_index   (thread_index),
        .resource_index (resource_index),
        .count_value    (count_value),
        .q_full         (q_full),
        .clearing       (clearing),
        .busy           (busy),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    // command queue
    dsc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .valid    (q_valid),
        .head     (q_head)
    );

    // stores and check sequencer
    dsc_back #(
        .THREADS   (THREADS),
        .RESOURCES (RESOURCES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .clearing   (clearing),
        .done       (done),
        .deadlocked (deadlocked)
    );

endmodule

// ----- rtl/dsc_front.sv -----
// front end: takes transactions, decodes them and drops out-of-range loads
module dsc_front
    import dsc_pkg::*;
#(
    parameter int THREADS   = 16,
    parameter int RESOURCES = 8
)
(
    input  logic                    start,
    input  logic [1:0]              mode,
    input  logic [THREAD_IDX_W-1:0] thread_index,
    input  logic [RES_IDX_W-1:0]    resource_index,
    input  logic [COUNT_W-1:0]      count_value,
    input  logic                    q_full,
    input  logic                    clearing,
    output logic                    busy,
    output logic                    push,
    output cmd_t                    push_cmd
);

    logic accept;
    logic res_ok;
    logic thr_ok;
    logic keep;
    op_t  op;

    // stall while the queue is full or the stores are being cleared
    assign busy   = q_full | clearing;
    assign accept = start & ~busy;

    // range checks against the configured array sizes
    assign res_ok = ({{(32-RES_IDX_W){1'b0}}, resource_index} < 32'(RESOURCES));
    assign thr_ok = ({{(32-THREAD_IDX_W){1'b0}}, thread_index} < 32'(THREADS));
    assign op     = op_t'(mode);

    // classify the transaction
    always_comb
    begin
        case (op)
            OP_CHECK: keep = 1'b1;
            OP_AVAIL: keep = res_ok;
            default:  keep = res_ok & thr_ok;
        endcase
    end

    assign push           = accept & keep;
    assign push_cmd.op     = op;
    assign push_cmd.thread = thread_index;
    assign push_cmd.res    = resource_index;
    assign push_cmd.value  = count_value;

endmodule

// ----- rtl/dsc_queue.sv -----
// short command queue that decouples the front end from the back end
module dsc_queue
    import dsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic valid,
    output cmd_t head
);

    cmd_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slots_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/dsc_back.sv -----
// back end: count stores, work vector and the thread pass sequencer
module dsc_back
    import dsc_pkg::*;
#(
    parameter int THREADS   = 16,
    parameter int RESOURCES = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  cmd_t q_head,
    output logic q_pop,
    output logic clearing,
    output logic done,
    output logic deadlocked
);

    localparam int TW    = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int RW    = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
    localparam int ROW_W = RESOURCES * COUNT_W;
    localparam logic [TW-1:0] LAST_T = TW'(THREADS - 1);

    back_state_t state_reg;
    back_state_t state_next;

    logic [TW-1:0]      clr_ptr_reg;
    logic [TW-1:0]      clr_ptr_next;
    logic [TW-1:0]      eval_t_reg;
    logic [TW-1:0]      eval_t_next;
    logic               progress_reg;
    logic               progress_next;
    logic [COUNT_W-1:0] avail_reg  [RESOURCES];
    logic [COUNT_W-1:0] avail_next [RESOURCES];
    logic [WORK_W-1:0]  work_reg   [RESOURCES];
    logic [WORK_W-1:0]  work_next  [RESOURCES];
    logic [THREADS-1:0] finish_reg;
    logic [THREADS-1:0] finish_next;
    logic               done_reg;
    logic               done_next;
    logic               dead_reg;
    logic               dead_next;

    // row-wide count memories, one row per thread
    logic [ROW_W-1:0]   alloc_mem [THREADS];
    logic [ROW_W-1:0]   req_mem   [THREADS];
    logic [ROW_W-1:0]   alloc_rd_reg;
    logic [ROW_W-1:0]   req_rd_reg;
    logic               alloc_we;
    logic               req_we;
    logic [TW-1:0]      mem_addr;
    logic [RESOURCES-1:0] mem_mask;
    logic [ROW_W-1:0]   mem_data;
    logic [TW-1:0]      rd_addr;

    // command index conversion to the store address widths
    logic [TW+THREAD_IDX_W-1:0] thr_wide;
    logic [RW+RES_IDX_W-1:0]    res_wide;
    logic [TW-1:0]              cmd_thr;
    logic [RW-1:0]              cmd_res;
    logic [RESOURCES-1:0]       res_onehot;

    // row evaluation
    logic [RESOURCES-1:0] fits_vec;
    logic [WORK_W-1:0]    released [RESOURCES];
    logic                 fits;
    logic                 last_t;
    logic                 pass_prog;
    logic [THREADS-1:0]   finish_upd;

    assign thr_wide = {{TW{1'b0}}, q_head.thread};
    assign res_wide = {{RW{1'b0}}, q_head.res};
    assign cmd_thr  = thr_wide[TW-1:0];
    assign cmd_res  = res_wide[RW-1:0];

    // per-resource compare and saturating release
    always_comb
    begin
        for (int r = 0; r < RESOURCES; r++)
        begin
            logic [COUNT_W-1:0] req_c;
            logic [COUNT_W-1:0] alloc_c;
            logic [WORK_W:0]    sum;
            req_c         = req_rd_reg[r*COUNT_W +: COUNT_W];
            alloc_c       = alloc_rd_reg[r*COUNT_W +: COUNT_W];
            fits_vec[r]   = ({{(WORK_W-COUNT_W){1'b0}}, req_c} <= work_reg[r]);
            sum           = {1'b0, work_reg[r]} + {{(WORK_W+1-COUNT_W){1'b0}}, alloc_c};
            released[r]   = sum[WORK_W] ? WORK_MAX : sum[WORK_W-1:0];
            res_onehot[r] = (cmd_res == RW'(r));
        end
    end

    assign fits      = (&fits_vec) & ~finish_reg[eval_t_reg];
    assign last_t    = (eval_t_reg == LAST_T);
    assign pass_prog = progress_reg | fits;

    always_comb
    begin
        finish_upd = finish_reg;
        if (fits)
        begin
            finish_upd[eval_t_reg] = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                if (clr_ptr_reg == LAST_T)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (q_valid && (q_head.op == OP_CHECK))
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (last_t && !pass_prog)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        q_pop         = 1'b0;
        alloc_we      = 1'b0;
        req_we        = 1'b0;
        mem_addr      = cmd_thr;
        mem_mask      = res_onehot;
        mem_data      = {RESOURCES{q_head.value}};
        clr_ptr_next  = clr_ptr_reg;
        eval_t_next   = eval_t_reg;
        progress_next = progress_reg;
        avail_next    = avail_reg;
        work_next     = work_reg;
        finish_next   = finish_reg;
        done_next     = 1'b0;
        dead_next     = 1'b0;
        case (state_reg)
            BK_CLEAR:
            begin
                alloc_we     = 1'b1;
                req_we       = 1'b1;
                mem_addr     = clr_ptr_reg;
                mem_mask     = '1;
                mem_data     = '0;
                clr_ptr_next = clr_ptr_reg + 1'b1;
            end
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_head.op)
                        OP_AVAIL:   avail_next[cmd_res] = q_head.value;
                        OP_ALLOC:   alloc_we = 1'b1;
                        OP_REQUEST: req_we = 1'b1;
                        OP_CHECK:
                        begin
                            for (int r = 0; r < RESOURCES; r++)
                            begin
                                work_next[r] = {{(WORK_W-COUNT_W){1'b0}}, avail_reg[r]};
                            end
                            finish_next   = '0;
                            eval_t_next   = '0;
                            progress_next = 1'b0;
                        end
                        default: q_pop = 1'b1;
                    endcase
                end
            end
            BK_SCAN:
            begin
                if (fits)
                begin
                    work_next = released;
                end
                finish_next = finish_upd;
                if (last_t)
                begin
                    eval_t_next   = '0;
                    progress_next = 1'b0;
                    if (!pass_prog)
                    begin
                        done_next = 1'b1;
                        dead_next = ~(&finish_upd);
                    end
                end
                else
                begin
                    eval_t_next   = eval_t_reg + 1'b1;
                    progress_next = pass_prog;
                end
            end
            default: q_pop = 1'b0;
        endcase
    end

    // the row read each cycle is the thread evaluated next cycle
    assign rd_addr = eval_t_next;

    // control and work registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_CLEAR;
            clr_ptr_reg  <= '0;
            eval_t_reg   <= '0;
            progress_reg <= 1'b0;
            finish_reg   <= '0;
            done_reg     <= 1'b0;
            dead_reg     <= 1'b0;
            for (int r = 0; r < RESOURCES; r++)
            begin
                avail_reg[r] <= '0;
                work_reg[r]  <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            clr_ptr_reg  <= clr_ptr_next;
            eval_t_reg   <= eval_t_next;
            progress_reg <= progress_next;
            finish_reg   <= finish_next;
            done_reg     <= done_next;
            dead_reg     <= dead_next;
            avail_reg    <= avail_next;
            work_reg     <= work_next;
        end
    end

    // count memories with per-resource write enables and registered read
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < RESOURCES; r++)
        begin
            if (alloc_we && mem_mask[r])
            begin
                alloc_mem[mem_addr][r*COUNT_W +: COUNT_W] <= mem_data[r*COUNT_W +: COUNT_W];
            end
            if (req_we && mem_mask[r])
            begin
                req_mem[mem_addr][r*COUNT_W +: COUNT_W] <= mem_data[r*COUNT_W +: COUNT_W];
            end
        end
        alloc_rd_reg <= alloc_mem[rd_addr];
        req_rd_reg   <= req_mem[rd_addr];
    end

    assign clearing   = (state_reg == BK_CLEAR);
    assign done       = done_reg;
    assign deadlocked = dead_reg;

endmodule

// ----- rtl/dsc_checker.sv -----
// port-level checker for the deadlock safety check block and its bind
module dsc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] mode,
    input logic       done,
    input logic       deadlocked
);

    // each check returns to idle and scans anew before its strobe, so results never come back to back
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe on two cycles in a row");

    // the clearing pass holds off transactions right after reset
    assert property (@(posedge clk) disable iff (!rst_n) !$past(rst_n) |-> busy)
        else $error("transaction window open during clearing pass");

    // result flag is quiet outside a result cycle
    assert property (@(posedge clk) disable iff (!rst_n) !done |-> !deadlocked)
        else $error("deadlocked high without a result strobe");

    // handshake and result ports stay known once out of reset
    assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({start, mode, busy, done, deadlocked}))
        else $error("unknown value on a handshake or result port");

endmodule

bind deadlock_safety_check_core dsc_checker u_dsc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .done       (done),
    .deadlocked (deadlocked)
);
